@@ hdl/rpt_pkg.sv @@
// Shared types and constants for the retransmit pending table.
// Used by the slot compare unit, the sequencer, the top level and the checker; depends on nothing.
`timescale 1ns / 1ps

package rpt_pkg;

    localparam int MAX_RESULTS = 16;
    localparam int CNT_W       = 5;

    localparam logic [31:0] INIT_TIMEOUT = 32'd1000;
    localparam logic [2:0]  INIT_RETRIES = 3'd5;

    localparam logic [1:0] FUNC_INSERT = 2'd0;
    localparam logic [1:0] FUNC_ACK    = 2'd1;
    localparam logic [1:0] FUNC_TICK   = 2'd2;

    localparam logic CFG_TIMEOUT = 1'b0;
    localparam logic CFG_RETRY   = 1'b1;

    typedef enum logic [2:0] {
        K_INSERTED   = 3'd0,
        K_FULL       = 3'd1,
        K_REMOVED    = 3'd2,
        K_NOTFOUND   = 3'd3,
        K_RETRANSMIT = 3'd4,
        K_DROPPED    = 3'd5,
        K_NONE       = 3'd6,
        K_EMPTY      = 3'd7
    } kind_t;

    typedef struct packed {
        logic [7:0]  msgid;
        logic [63:0] peer_high;
        logic [63:0] peer_low;
        logic [31:0] sent_time;
        logic [2:0]  retries;
    } slot_t;

    typedef struct packed {
        logic [7:0]  msgid;
        logic [63:0] peer_high;
        logic [63:0] peer_low;
        logic [31:0] now;
    } req_t;

    typedef struct packed {
        logic match;
        logic due;
    } eval_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  msgid;
        logic [63:0] peer_high;
        logic [63:0] peer_low;
    } result_t;

endpackage

@@ hdl/rpt_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependency.
`timescale 1ns / 1ps

module rpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic                                   rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ hdl/rpt_slot_eval.sv @@
// Shared compare unit: checks one slot against the held request.
// Depends on rpt_pkg for the slot, request and result types.
`timescale 1ns / 1ps

module rpt_slot_eval (
    input  logic          slot_valid,
    input  rpt_pkg::slot_t slot,
    input  rpt_pkg::req_t  req,
    input  logic [31:0]    timeout,
    output rpt_pkg::eval_t result
);

    logic [31:0] age;

    // Wrapping difference, modulo 2^32
    assign age = req.now - slot.sent_time;

    assign result.match = slot_valid && (slot.msgid == req.msgid) &&
                          (slot.peer_high == req.peer_high) &&
                          (slot.peer_low == req.peer_low);
    assign result.due   = slot_valid && (age > timeout);

endmodule

@@ hdl/rpt_ctrl.sv @@
// Sequencer of the pending table: valid bits, slot scan, result output.
// Depends on rpt_pkg; drives the slot RAM and reads the shared compare unit.
`timescale 1ns / 1ps

module rpt_ctrl #(
    parameter int ENTRIES = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [1:0]            func,
    input  logic [7:0]            msgid,
    input  logic [63:0]           peer_high,
    input  logic [63:0]           peer_low,
    input  logic [31:0]           now,
    input  logic [2:0]            retry_limit,
    output rpt_pkg::req_t         req,
    output logic                  cur_valid,
    input  rpt_pkg::eval_t        eval,
    input  rpt_pkg::slot_t        rd_data,
    output logic                  rd_en,
    output logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] rd_addr,
    output logic                  wr_en,
    output logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] wr_addr,
    output rpt_pkg::slot_t        wr_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output rpt_pkg::result_t      out_result,
    output logic                  out_last
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_INS,
        S_SCAN,
        S_FIN
    } state_t;

    state_t                     state_reg, state_next;
    logic [IDX_W-1:0]           idx_reg, idx_next;
    logic [rpt_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic [ENTRIES-1:0]         valid_reg, valid_next;
    rpt_pkg::req_t              req_reg, req_next;
    logic [1:0]                 func_reg, func_next;
    logic                       pend_valid_reg, pend_valid_next;
    rpt_pkg::result_t           pend_reg, pend_next;
    rpt_pkg::kind_t             fin_kind_reg, fin_kind_next;
    logic                       out_valid_reg, out_valid_next;
    rpt_pkg::result_t           out_reg, out_next;
    logic                       out_last_reg, out_last_next;

    logic last_slot;
    logic out_free;

    assign last_slot = (idx_reg == IDX_W'(ENTRIES - 1));
    assign out_free  = !out_valid_reg || !out_stall;
    assign cur_valid = valid_reg[idx_reg];
    assign req       = req_reg;
    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_result = out_reg;
    assign out_last  = out_last_reg;

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        cnt_next        = cnt_reg;
        valid_next      = valid_reg;
        req_next        = req_reg;
        func_next       = func_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        fin_kind_next   = fin_kind_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_next        = out_reg;
        out_last_next   = out_last_reg;
        rd_en           = 1'b0;
        rd_addr         = '0;
        wr_en           = 1'b0;
        wr_addr         = idx_reg;
        wr_data         = rd_data;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    req_next        = '{msgid: msgid, peer_high: peer_high,
                                        peer_low: peer_low, now: now};
                    func_next       = func;
                    idx_next        = '0;
                    cnt_next        = '0;
                    pend_valid_next = 1'b0;
                    case (func)
                        rpt_pkg::FUNC_INSERT:
                        begin
                            state_next = S_INS;
                        end
                        rpt_pkg::FUNC_ACK:
                        begin
                            rd_en      = 1'b1;
                            state_next = S_SCAN;
                        end
                        rpt_pkg::FUNC_TICK:
                        begin
                            if (valid_reg == '0)
                            begin
                                fin_kind_next = rpt_pkg::K_EMPTY;
                                state_next    = S_FIN;
                            end
                            else
                            begin
                                fin_kind_next = rpt_pkg::K_NONE;
                                rd_en         = 1'b1;
                                state_next    = S_SCAN;
                            end
                        end
                        default:
                        begin
                            // unused code: drop the transfer
                        end
                    endcase
                end
            end

            S_INS:
            begin
                if (!valid_reg[idx_reg])
                begin
                    if (out_free)
                    begin
                        wr_en               = 1'b1;
                        wr_data             = '{msgid: req_reg.msgid,
                                                peer_high: req_reg.peer_high,
                                                peer_low: req_reg.peer_low,
                                                sent_time: req_reg.now,
                                                retries: retry_limit};
                        valid_next[idx_reg] = 1'b1;
                        out_valid_next      = 1'b1;
                        out_next            = '{kind: rpt_pkg::K_INSERTED,
                                                msgid: req_reg.msgid,
                                                peer_high: req_reg.peer_high,
                                                peer_low: req_reg.peer_low};
                        out_last_next       = 1'b1;
                        state_next          = S_IDLE;
                    end
                end
                else if (last_slot)
                begin
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        out_next       = '{kind: rpt_pkg::K_FULL,
                                           msgid: req_reg.msgid,
                                           peer_high: req_reg.peer_high,
                                           peer_low: req_reg.peer_low};
                        out_last_next  = 1'b1;
                        state_next     = S_IDLE;
                    end
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end

            S_SCAN:
            begin
                if (func_reg == rpt_pkg::FUNC_ACK)
                begin
                    if (eval.match || last_slot)
                    begin
                        if (out_free)
                        begin
                            if (eval.match)
                            begin
                                valid_next[idx_reg] = 1'b0;
                            end
                            out_valid_next = 1'b1;
                            out_next       = '{kind: eval.match ? rpt_pkg::K_REMOVED
                                                                : rpt_pkg::K_NOTFOUND,
                                               msgid: req_reg.msgid,
                                               peer_high: req_reg.peer_high,
                                               peer_low: req_reg.peer_low};
                            out_last_next  = 1'b1;
                            state_next     = S_IDLE;
                        end
                    end
                    else
                    begin
                        rd_en    = 1'b1;
                        rd_addr  = idx_reg + IDX_W'(1);
                        idx_next = idx_reg + IDX_W'(1);
                    end
                end
                else if (eval.due)
                begin
                    // Hold until the previous due slot can leave as a non-final result
                    if (!pend_valid_reg || out_free)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_valid_next = 1'b1;
                            out_next       = pend_reg;
                            out_last_next  = 1'b0;
                        end
                        pend_valid_next   = 1'b1;
                        wr_en             = 1'b1;
                        wr_data.sent_time = req_reg.now;
                        if (rd_data.retries == 3'd0)
                        begin
                            valid_next[idx_reg] = 1'b0;
                            pend_next.kind      = rpt_pkg::K_DROPPED;
                        end
                        else
                        begin
                            wr_data.retries = rd_data.retries - 3'd1;
                            pend_next.kind  = rpt_pkg::K_RETRANSMIT;
                        end
                        pend_next.msgid     = rd_data.msgid;
                        pend_next.peer_high = rd_data.peer_high;
                        pend_next.peer_low  = rd_data.peer_low;
                        cnt_next            = cnt_reg + rpt_pkg::CNT_W'(1);
                        if (last_slot ||
                            cnt_reg == rpt_pkg::CNT_W'(rpt_pkg::MAX_RESULTS - 1))
                        begin
                            state_next = S_FIN;
                        end
                        else
                        begin
                            rd_en    = 1'b1;
                            rd_addr  = idx_reg + IDX_W'(1);
                            idx_next = idx_reg + IDX_W'(1);
                        end
                    end
                end
                else if (last_slot)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    rd_en    = 1'b1;
                    rd_addr  = idx_reg + IDX_W'(1);
                    idx_next = idx_reg + IDX_W'(1);
                end
            end

            S_FIN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_last_next  = 1'b1;
                    if (pend_valid_reg)
                    begin
                        out_next = pend_reg;
                    end
                    else
                    begin
                        out_next = '{kind: fin_kind_reg, msgid: 8'd0,
                                     peer_high: 64'd0, peer_low: 64'd0};
                    end
                    pend_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            idx_reg        <= '0;
            cnt_reg        <= '0;
            valid_reg      <= '0;
            req_reg        <= '0;
            func_reg       <= rpt_pkg::FUNC_INSERT;
            pend_valid_reg <= 1'b0;
            pend_reg       <= '0;
            fin_kind_reg   <= rpt_pkg::K_NONE;
            out_valid_reg  <= 1'b0;
            out_reg        <= '0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            cnt_reg        <= cnt_next;
            valid_reg      <= valid_next;
            req_reg        <= req_next;
            func_reg       <= func_next;
            pend_valid_reg <= pend_valid_next;
            pend_reg       <= pend_next;
            fin_kind_reg   <= fin_kind_next;
            out_valid_reg  <= out_valid_next;
            out_reg        <= out_next;
            out_last_reg   <= out_last_next;
        end
    end

endmodule

@@ hdl/retransmit_pending_table_top.sv @@
// Top level of the retransmit pending table: config registers and wiring.
// Depends on rpt_pkg, rpt_ram, rpt_slot_eval and rpt_ctrl.
//
//   channel   direction  handshake            payload
//   input     in         in_valid / in_stall  func, msgid, peer_high, peer_low, now
//   output    out        out_valid / out_stall kind, out_msgid, out_peer_high,
//                                             out_peer_low, last
//   config    in         cfg_we               cfg_index, cfg_data
//
// One slot is handled per cycle through the single RAM read port and the shared
// compare unit, as long as no result is stalled at the output: a stalled result
// holds the scan at the next result. Reset clears valid bits and loads timeout
// 1000, retries 5.
`timescale 1ns / 1ps

module retransmit_pending_table_top #(
    parameter int ENTRIES = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  func,
    input  logic [7:0]  msgid,
    input  logic [63:0] peer_high,
    input  logic [63:0] peer_low,
    input  logic [31:0] now,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  kind,
    output logic [7:0]  out_msgid,
    output logic [63:0] out_peer_high,
    output logic [63:0] out_peer_low,
    output logic        last,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int SLOT_W = $bits(rpt_pkg::slot_t);

    logic [31:0]      timeout_reg;
    logic [2:0]       retry_reg;

    rpt_pkg::req_t    req;
    rpt_pkg::eval_t   eval;
    rpt_pkg::slot_t   rd_data;
    rpt_pkg::slot_t   wr_data;
    rpt_pkg::result_t out_result;
    logic             cur_valid;
    logic             rd_en;
    logic             wr_en;
    logic [IDX_W-1:0] rd_addr;
    logic [IDX_W-1:0] wr_addr;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= rpt_pkg::INIT_TIMEOUT;
            retry_reg   <= rpt_pkg::INIT_RETRIES;
        end
        else if (cfg_we)
        begin
            if (cfg_index == rpt_pkg::CFG_TIMEOUT)
            begin
                timeout_reg <= cfg_data;
            end
            else if (cfg_index == rpt_pkg::CFG_RETRY)
            begin
                retry_reg <= cfg_data[2:0];
            end
        end
    end

    rpt_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (ENTRIES)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    rpt_slot_eval u_eval (
        .slot_valid (cur_valid),
        .slot       (rd_data),
        .req        (req),
        .timeout    (timeout_reg),
        .result     (eval)
    );

    rpt_ctrl #(
        .ENTRIES (ENTRIES)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .func        (func),
        .msgid       (msgid),
        .peer_high   (peer_high),
        .peer_low    (peer_low),
        .now         (now),
        .retry_limit (retry_reg),
        .req         (req),
        .cur_valid   (cur_valid),
        .eval        (eval),
        .rd_data     (rd_data),
        .rd_en       (rd_en),
        .rd_addr     (rd_addr),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_result  (out_result),
        .out_last    (last)
    );

    assign kind          = out_result.kind;
    assign out_msgid     = out_result.msgid;
    assign out_peer_high = out_result.peer_high;
    assign out_peer_low  = out_result.peer_low;

endmodule

@@ hdl/rpt_checker.sv @@
// Port-level checks for the retransmit pending table, bound to the top level.
// Depends on rpt_pkg for the result kind codes.
`timescale 1ns / 1ps

module rpt_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic [1:0]  func,
    input logic        out_valid,
    input logic        out_stall,
    input logic [2:0]  kind,
    input logic [7:0]  out_msgid,
    input logic [63:0] out_peer_high,
    input logic [63:0] out_peer_low,
    input logic        last
);

    // A stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // A transfer with a used code keeps the block busy in the next cycle
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall &&
        (func == rpt_pkg::FUNC_INSERT || func == rpt_pkg::FUNC_ACK ||
         func == rpt_pkg::FUNC_TICK) |=> in_stall)
        else $error("input not held off after transfer");

    // Single-result kinds always close their item
    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == rpt_pkg::K_INSERTED || kind == rpt_pkg::K_FULL ||
                      kind == rpt_pkg::K_REMOVED || kind == rpt_pkg::K_NOTFOUND ||
                      kind == rpt_pkg::K_NONE || kind == rpt_pkg::K_EMPTY) |-> last)
        else $error("single result without last");

    // Empty and nothing-due results carry zero fields
    a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == rpt_pkg::K_NONE || kind == rpt_pkg::K_EMPTY) |->
        (out_msgid == 8'd0) && (out_peer_high == 64'd0) && (out_peer_low == 64'd0))
        else $error("status result with nonzero fields");

endmodule

bind retransmit_pending_table_top rpt_checker u_rpt_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .func          (func),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .kind          (kind),
    .out_msgid     (out_msgid),
    .out_peer_high (out_peer_high),
    .out_peer_low  (out_peer_low),
    .last          (last)
);

@@ tb/sv/tb_retransmit_pending_table_top.sv @@
`timescale 1ns / 1ps

// Self-checking bench for retransmit_pending_table_top: a table model tracks slot
// contents and queues the replies each transfer should produce, a monitor checks them.
// Depends on rpt_pkg and the retransmit_pending_table_top RTL.

typedef struct packed {
    rpt_pkg::kind_t kind;
    logic [7:0]     msgid;
    logic [63:0]    peer_high;
    logic [63:0]    peer_low;
    logic           last;
} table_reply_t;

class pending_table_scoreboard #(int SLOTS = 16);
    logic [31:0]  timeout_ticks;
    logic [2:0]   retry_budget;
    bit           occupied[SLOTS];
    logic [7:0]   entry_id[SLOTS];
    logic [63:0]  entry_hi[SLOTS];
    logic [63:0]  entry_lo[SLOTS];
    logic [31:0]  entry_sent[SLOTS];
    logic [2:0]   entry_tries[SLOTS];
    table_reply_t replies_owed[$];
    int           mismatches;

    function new();
        timeout_ticks = rpt_pkg::INIT_TIMEOUT;
        retry_budget  = rpt_pkg::INIT_RETRIES;
        mismatches    = 0;
        foreach (occupied[i])
            occupied[i] = 1'b0;
    endfunction

    function void write_reg(logic idx, logic [31:0] data);
        if (idx == rpt_pkg::CFG_TIMEOUT)
            timeout_ticks = data;
        else
            retry_budget = data[2:0];
    endfunction

    function table_reply_t reply(rpt_pkg::kind_t kind, logic [7:0] id, logic [63:0] hi,
                                 logic [63:0] lo);
        table_reply_t r;
        r.kind      = kind;
        r.msgid     = id;
        r.peer_high = hi;
        r.peer_low  = lo;
        r.last      = 1'b0;
        return r;
    endfunction

    // Update the table for one accepted request and queue the replies it causes.
    function void apply_request(logic [1:0] func, logic [7:0] id, logic [63:0] hi,
                                logic [63:0] lo, logic [31:0] now);
        table_reply_t batch[$];
        logic [31:0]  age;
        int           slot;
        bit           any;
        slot = -1;
        any  = 1'b0;
        case (func)
            rpt_pkg::FUNC_INSERT:
            begin
                foreach (occupied[i])
                    if (!occupied[i] && slot < 0)
                        slot = i;
                if (slot < 0)
                    batch.push_back(reply(rpt_pkg::K_FULL, id, hi, lo));
                else
                begin
                    occupied[slot]    = 1'b1;
                    entry_id[slot]    = id;
                    entry_hi[slot]    = hi;
                    entry_lo[slot]    = lo;
                    entry_sent[slot]  = now;
                    entry_tries[slot] = retry_budget;
                    batch.push_back(reply(rpt_pkg::K_INSERTED, id, hi, lo));
                end
            end
            rpt_pkg::FUNC_ACK:
            begin
                foreach (occupied[i])
                    if (slot < 0 && occupied[i] && entry_id[i] == id && entry_hi[i] == hi
                        && entry_lo[i] == lo)
                        slot = i;
                if (slot < 0)
                    batch.push_back(reply(rpt_pkg::K_NOTFOUND, id, hi, lo));
                else
                begin
                    occupied[slot] = 1'b0;
                    batch.push_back(reply(rpt_pkg::K_REMOVED, id, hi, lo));
                end
            end
            rpt_pkg::FUNC_TICK:
            begin
                foreach (occupied[i])
                    any |= occupied[i];
                if (!any)
                    batch.push_back(reply(rpt_pkg::K_EMPTY, 8'd0, 64'd0, 64'd0));
                else
                begin
                    for (int i = 0; i < SLOTS && batch.size() < rpt_pkg::MAX_RESULTS; i++)
                    begin
                        if (!occupied[i])
                            continue;
                        age = now - entry_sent[i];
                        if (age <= timeout_ticks)
                            continue;
                        if (entry_tries[i] == 3'd0)
                        begin
                            occupied[i] = 1'b0;
                            batch.push_back(reply(rpt_pkg::K_DROPPED, entry_id[i],
                                                  entry_hi[i], entry_lo[i]));
                        end
                        else
                        begin
                            entry_tries[i] = entry_tries[i] - 3'd1;
                            batch.push_back(reply(rpt_pkg::K_RETRANSMIT, entry_id[i],
                                                  entry_hi[i], entry_lo[i]));
                        end
                        entry_sent[i] = now;
                    end
                    if (batch.size() == 0)
                        batch.push_back(reply(rpt_pkg::K_NONE, 8'd0, 64'd0, 64'd0));
                end
            end
            default: ;
        endcase
        if (batch.size() > 0)
        begin
            batch[batch.size() - 1].last = 1'b1;
            foreach (batch[i])
                replies_owed.push_back(batch[i]);
        end
    endfunction

    function void compare(string field, logic [63:0] want, logic [63:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, actual 0x%0h", field, want, got);
            mismatches++;
        end
    endfunction

    function void check_result(logic [2:0] kind, logic [7:0] id, logic [63:0] hi,
                               logic [63:0] lo, logic last);
        table_reply_t want;
        if (replies_owed.size() == 0)
        begin
            $error("unexpected reply: kind %0d msgid 0x%0h", kind, id);
            mismatches++;
            return;
        end
        want = replies_owed.pop_front();
        compare("kind", 64'(want.kind), 64'(kind));
        compare("out_msgid", 64'(want.msgid), 64'(id));
        compare("out_peer_high", want.peer_high, hi);
        compare("out_peer_low", want.peer_low, lo);
        compare("last", 64'(want.last), 64'(last));
    endfunction
endclass

module tb_retransmit_pending_table_top;

    localparam int         TABLE_DEPTH = 16;
    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam int         LONG_HOLD   = 300;
    localparam int         SETTLE      = TABLE_DEPTH + 8;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_stall;
    logic [1:0]  func      = '0;
    logic [7:0]  msgid     = '0;
    logic [63:0] peer_high = '0;
    logic [63:0] peer_low  = '0;
    logic [31:0] now       = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [2:0]  kind;
    logic [7:0]  out_msgid;
    logic [63:0] out_peer_high;
    logic [63:0] out_peer_low;
    logic        last;
    logic        cfg_we    = 1'b0;
    logic        cfg_index = 1'b0;
    logic [31:0] cfg_data  = '0;

    pending_table_scoreboard #(TABLE_DEPTH) sb;
    logic [31:0] cur_now  = '0;
    logic        calm     = 1'b0;
    logic        hold_req = 1'b0;
    logic [63:0] pool_hi[4];
    logic [63:0] pool_lo[4];

    retransmit_pending_table_top #(
        .ENTRIES(TABLE_DEPTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .func(func),
        .msgid(msgid),
        .peer_high(peer_high),
        .peer_low(peer_low),
        .now(now),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .kind(kind),
        .out_msgid(out_msgid),
        .out_peer_high(out_peer_high),
        .out_peer_low(out_peer_low),
        .last(last),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #10 clk = ~clk;

    task automatic send_item(logic [1:0] f, logic [7:0] id, logic [63:0] hi,
                             logic [63:0] lo, logic [31:0] t);
        in_valid  <= 1'b1;
        func      <= f;
        msgid     <= id;
        peer_high <= hi;
        peer_low  <= lo;
        now       <= t;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.apply_request(f, id, hi, lo, t);
    endtask

    task automatic sender_gap();
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
    endtask

    // Hold the input until every queued reply has come out, then let the block settle.
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.replies_owed.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic program_reg(logic idx, logic [31:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.write_reg(idx, data);
        @(posedge clk);
    endtask

    task automatic random_item();
        int          pick;
        int          slot;
        int          i;
        int          live[$];
        logic [5:0]  bitpos;
        logic [7:0]  id;
        logic [63:0] hi;
        logic [63:0] lo;
        logic [31:0] step;
        pick   = $urandom_range(0, 99);
        bitpos = 6'($urandom);
        id     = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 7));
        slot   = $urandom_range(0, 3);
        hi     = pool_hi[slot];
        lo     = pool_lo[slot];
        if ($urandom_range(0, 4) == 0)
        begin
            hi = {$urandom, $urandom};
            lo = {$urandom, $urandom};
        end
        if (pick < 35)
            send_item(rpt_pkg::FUNC_INSERT, id, hi, lo, cur_now);
        else if (pick < 60)
        begin
            for (i = 0; i < TABLE_DEPTH; i++)
                if (sb.occupied[i])
                    live.push_back(i);
            if (live.size() > 0)
            begin
                slot = live[$urandom_range(0, live.size() - 1)];
                id   = sb.entry_id[slot];
                hi   = sb.entry_hi[slot];
                lo   = sb.entry_lo[slot];
                // near miss: one bit off in the id or in one address half
                case ($urandom_range(0, 9))
                    0: id = id ^ (8'd1 << bitpos[2:0]);
                    1: hi = hi ^ (64'd1 << bitpos);
                    2: lo = lo ^ (64'd1 << bitpos);
                    default: ;
                endcase
            end
            send_item(rpt_pkg::FUNC_ACK, id, hi, lo, cur_now);
        end
        else if (pick < 88)
        begin
            case ($urandom_range(0, 2))
                0: step = $urandom_range(0, 50);
                1: step = sb.timeout_ticks - 5 + $urandom_range(0, 10);
                default: step = $urandom;
            endcase
            cur_now = cur_now + step;
            send_item(rpt_pkg::FUNC_TICK, id, hi, lo, cur_now);
        end
        else
            send_item(2'($urandom_range(0, 3)), 8'($urandom), {$urandom, $urandom},
                      {$urandom, $urandom}, $urandom);
        sender_gap();
    endtask

    task automatic run_phase(logic [31:0] tmo, logic [2:0] tries, int count);
        int n;
        drain();
        program_reg(rpt_pkg::CFG_TIMEOUT, tmo);
        program_reg(rpt_pkg::CFG_RETRY, ($urandom & 32'hFFFF_FFF8) | 32'(tries));
        for (n = 0; n < count; n++)
            random_item();
    endtask

    initial
    begin : receiver
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req  <= 1'b0;
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                out_stall <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 3) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 5)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    initial
    begin : result_monitor
        logic [2:0]  k;
        logic [7:0]  id;
        logic [63:0] hi;
        logic [63:0] lo;
        logic        l;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                k  = kind;
                id = out_msgid;
                hi = out_peer_high;
                lo = out_peer_low;
                l  = last;
                // check after the request accepted at this edge has been applied
                #1;
                sb.check_result(k, id, hi, lo, l);
            end
        end
    end

    initial
    begin : watchdog
        #8_000_000;
        $display("retransmit_pending_table_top regression: fail");
        $finish;
    end

    initial
    begin : stimulus
        int i;
        sb = new();
        for (i = 0; i < 4; i++)
        begin
            pool_hi[i] = {$urandom, $urandom};
            pool_lo[i] = {$urandom, $urandom};
        end
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // tick and ack on an empty table, then an unused code that must be ignored
        send_item(rpt_pkg::FUNC_TICK, 8'hFF, '1, '1, 32'hFFFF_FFFF);
        sender_gap();
        send_item(rpt_pkg::FUNC_ACK, 8'h5A, pool_hi[0], pool_lo[0], 32'd0);
        send_item(FUNC_UNUSED, 8'hA5, {$urandom, $urandom}, {$urandom, $urandom}, $urandom);

        // fill every slot, extremes first, then one insert too many
        send_item(rpt_pkg::FUNC_INSERT, 8'h00, 64'd0, 64'd0, 32'd0);
        send_item(rpt_pkg::FUNC_INSERT, 8'hFF, '1, '1, 32'd0);
        for (i = 2; i < TABLE_DEPTH; i++)
        begin
            send_item(rpt_pkg::FUNC_INSERT, 8'(i), pool_hi[i % 4], pool_lo[i % 4],
                      32'(i * 10));
            sender_gap();
        end
        send_item(rpt_pkg::FUNC_INSERT, 8'hC3, pool_hi[1], pool_lo[1], 32'd200);

        // ack must match id and whole address
        send_item(rpt_pkg::FUNC_ACK, 8'hFF, '1, 64'hFFFF_FFFF_FFFF_FFFE, 32'd0);
        send_item(rpt_pkg::FUNC_ACK, 8'hFE, '1, '1, 32'd0);
        send_item(rpt_pkg::FUNC_ACK, 8'hFF, '1, '1, 32'd0);

        // nothing due, everything due, then age exactly at the timeout
        send_item(rpt_pkg::FUNC_TICK, 8'h00, 64'd0, 64'd0, 32'd500);
        send_item(rpt_pkg::FUNC_TICK, 8'h00, 64'd0, 64'd0, 32'd2000);
        send_item(rpt_pkg::FUNC_TICK, 8'h00, 64'd0, 64'd0, 32'd3000);
        cur_now = 32'd3000;

        // stall the output for a long stretch while inserts keep coming
        hold_req <= 1'b1;
        for (i = 0; i < 30; i++)
            send_item(rpt_pkg::FUNC_INSERT, 8'($urandom), {$urandom, $urandom},
                      {$urandom, $urandom}, cur_now);

        run_phase(32'd1000, 3'd5, 60);
        cur_now = 32'hFFFF_FF00;
        run_phase(32'd0, 3'd0, 60);
        run_phase(32'hFFFF_FFFF, 3'd7, 50);
        run_phase(32'($urandom_range(100, 5000)), 3'($urandom_range(1, 6)), 80);
        calm <= 1'b1;
        run_phase(32'd2, 3'd1, 60);
        drain();

        if (sb.mismatches == 0)
            $display("retransmit_pending_table_top regression: pass");
        else
            $display("retransmit_pending_table_top regression: fail");
        $finish;
    end
endmodule
